// ----- hdl/rcmm_pkg.sv -----
// Shared types, codes and timing constants of the RCMM frame encoder.
// No dependencies; imported by every module of the block.
package rcmm_pkg;

	localparam int WORD_BITS_DEF = 32;

	localparam int DUR_W    = 5;
	localparam int PAIRS_W  = 5;
	localparam int PAUSE_W  = 8;
	localparam int CMD_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// Segment lengths in carrier periods
	localparam logic [DUR_W-1:0] HEAD_MARK_LEN  = 5'd15;
	localparam logic [DUR_W-1:0] HEAD_SPACE_LEN = 5'd10;
	localparam logic [DUR_W-1:0] SYM_MARK_LEN   = 5'd6;
	localparam logic [DUR_W-1:0] TRAIL_MARK_LEN = 5'd6;
	localparam logic [DUR_W-1:0] TRAIL_GAP_LEN  = 5'd1;
	localparam logic [DUR_W-1:0] PAUSE_SEG_LEN  = 5'd6;

	localparam logic [PAIRS_W-1:0] FRAME_PAIRS_RST = 5'd16;
	localparam logic [PAUSE_W-1:0] PAUSE_TICKS_RST = 8'd110;

	typedef enum logic [1:0] {
		MODE_TICK   = 2'd0,
		MODE_SEND   = 2'd1,
		MODE_REPEAT = 2'd2,
		MODE_STOP   = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_PAIRS = 2'd0,
		CFG_TRAILER_EN  = 2'd1,
		CFG_PAUSE_TICKS = 2'd2,
		CFG_UNUSED      = 2'd3
	} cfg_idx_t;

	typedef enum logic [6:0] {
		PH_IDLE       = 7'b0000001,
		PH_HEAD_MARK  = 7'b0000010,
		PH_HEAD_SPACE = 7'b0000100,
		PH_SYM_MARK   = 7'b0001000,
		PH_SYM_SPACE  = 7'b0010000,
		PH_TRAIL      = 7'b0100000,
		PH_PAUSE      = 7'b1000000
	} phase_t;

	typedef struct packed {
		mode_t            mode;
		logic [CMD_W-1:0] command;
	} item_t;

	typedef struct packed {
		logic             carrier_on;
		logic [DUR_W-1:0] duration;
		logic             duration_valid;
		logic             frame_active;
	} res_t;

	typedef struct packed {
		logic             we;
		cfg_idx_t         idx;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	function automatic logic [DUR_W-1:0] space_len(input logic [1:0] sym);
		logic [DUR_W-1:0] len;
		case (sym)
			2'd0:    len = 5'd10;
			2'd1:    len = 5'd16;
			2'd2:    len = 5'd22;
			default: len = 5'd28;
		endcase
		return len;
	endfunction

endpackage

// ----- hdl/rcmm_in_stage.sv -----
// Input register of the RCMM encoder: holds one accepted event beat.
// Depends on rcmm_pkg.
module rcmm_in_stage
	import rcmm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  item_t in_item,
	input  logic  adv,
	output logic  valid_s1,
	output item_t item_s1
);

	logic take;

	assign in_stall = valid_s1 & ~adv;
	assign take     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ----- hdl/rcmm_seq.sv -----
// Frame sequencer of the RCMM encoder: frame state, settings and next-segment logic.
// Depends on rcmm_pkg.
module rcmm_seq
	import rcmm_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
)(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  item_t   item_s1,
	input  cfg_wr_t cfg,
	output res_t    res
);

	phase_t               phase_q, phase_n;
	logic [WORD_BITS-1:0] shift_q, shift_n;
	logic [WORD_BITS-1:0] stored_q, stored_n;
	logic [PAIRS_W-1:0]   pair_q, pair_n;
	logic [PAUSE_W-1:0]   pause_q, pause_n;
	logic                 carrier_q, carrier_n;

	logic [PAIRS_W-1:0]   frame_pairs_q;
	logic                 trailer_en_q;
	logic [PAUSE_W-1:0]   pause_ticks_q, pause_ticks_n;

	logic [WORD_BITS-1:0] cmd;
	logic [DUR_W-1:0]     dur;
	logic                 dur_vld;
	logic                 start;

	assign cmd = item_s1.command[WORD_BITS-1:0];

	always_comb begin
		phase_n       = phase_q;
		shift_n       = shift_q;
		stored_n      = stored_q;
		pair_n        = pair_q;
		pause_n       = pause_q;
		carrier_n     = carrier_q;
		pause_ticks_n = pause_ticks_q;
		dur           = '0;
		dur_vld       = 1'b0;
		start         = 1'b0;

		unique case (item_s1.mode)
			MODE_SEND: begin
				stored_n = cmd;
				start    = (cmd != '0) && (phase_q == PH_IDLE);
			end
			MODE_REPEAT: begin
				start = (stored_q != '0) && (phase_q == PH_IDLE);
			end
			MODE_STOP: begin
				stored_n = '0;
			end
			default: begin
				unique case (phase_q)
					PH_HEAD_MARK: begin
						carrier_n = 1'b1;
						dur       = HEAD_MARK_LEN;
						dur_vld   = 1'b1;
						phase_n   = PH_HEAD_SPACE;
					end
					PH_HEAD_SPACE: begin
						carrier_n = 1'b0;
						dur       = HEAD_SPACE_LEN;
						dur_vld   = 1'b1;
						phase_n   = PH_SYM_MARK;
					end
					PH_SYM_MARK: begin
						carrier_n = 1'b1;
						dur       = SYM_MARK_LEN;
						dur_vld   = 1'b1;
						phase_n   = PH_SYM_SPACE;
					end
					PH_SYM_SPACE: begin
						carrier_n = 1'b0;
						dur       = space_len(shift_q[WORD_BITS-1 -: 2]);
						dur_vld   = 1'b1;
						shift_n   = {shift_q[WORD_BITS-3:0], 2'b00};
						pair_n    = pair_q + 1'b1;
						phase_n   = (pair_n == frame_pairs_q) ? PH_TRAIL : PH_SYM_MARK;
					end
					PH_TRAIL: begin
						// without trailer the one-period gap keeps the held level
						if (trailer_en_q) begin
							carrier_n = 1'b1;
							dur       = TRAIL_MARK_LEN;
						end else begin
							dur = TRAIL_GAP_LEN;
						end
						dur_vld = 1'b1;
						phase_n = PH_PAUSE;
					end
					PH_PAUSE: begin
						carrier_n = 1'b0;
						dur       = PAUSE_SEG_LEN;
						dur_vld   = 1'b1;
						pause_n   = pause_q + 1'b1;
						if (pause_n >= pause_ticks_q) begin
							pair_n        = '0;
							pause_n       = '0;
							pause_ticks_n = PAUSE_TICKS_RST;
							phase_n       = PH_IDLE;
						end
					end
					default: begin
						carrier_n = 1'b0;
						phase_n   = PH_IDLE;
					end
				endcase
			end
		endcase

		if (start) begin
			shift_n = stored_n;
			phase_n = PH_HEAD_MARK;
		end
	end

	assign res.carrier_on     = carrier_n;
	assign res.duration       = dur;
	assign res.duration_valid = dur_vld;
	assign res.frame_active   = (phase_n != PH_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			shift_q   <= '0;
			stored_q  <= '0;
			pair_q    <= '0;
			pause_q   <= '0;
			carrier_q <= 1'b0;
		end else if (adv) begin
			phase_q   <= phase_n;
			shift_q   <= shift_n;
			stored_q  <= stored_n;
			pair_q    <= pair_n;
			pause_q   <= pause_n;
			carrier_q <= carrier_n;
		end
	end

	// settings; pause length falls back to its default at the end of each pause
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pairs_q <= FRAME_PAIRS_RST;
			trailer_en_q  <= 1'b1;
			pause_ticks_q <= PAUSE_TICKS_RST;
		end else begin
			if (adv) begin
				pause_ticks_q <= pause_ticks_n;
			end
			if (cfg.we) begin
				unique case (cfg.idx)
					CFG_FRAME_PAIRS: frame_pairs_q <= cfg.data[PAIRS_W-1:0];
					CFG_TRAILER_EN:  trailer_en_q  <= cfg.data[0];
					CFG_PAUSE_TICKS: pause_ticks_q <= cfg.data[PAUSE_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- hdl/rcmm_out_stage.sv -----
// Result register of the RCMM encoder: holds one result beat until taken.
// Depends on rcmm_pkg.
module rcmm_out_stage
	import rcmm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic valid_s1,
	input  res_t res,
	input  logic out_stall,
	output logic adv,
	output logic out_valid,
	output res_t res_q
);

	logic out_valid_q;

	assign adv       = valid_s1 & (~out_valid_q | ~out_stall);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

endmodule

// ----- hdl/rcmm_ir_frame_encoder_core.sv -----
// RCMM infrared frame encoder, top level.
// Usage:
//   Event beats arrive on in_valid/in_stall with mode and command: tick (the
//   current carrier segment is over), send, repeat or stop. Every event beat
//   yields exactly one result beat on out_valid/out_stall: carrier_on, duration,
//   duration_valid and frame_active. A tick during a frame gives the next
//   segment; other events report duration 0 with duration_valid low.
//   Settings are written through cfg_we/cfg_idx/cfg_wdata while the block is
//   idle: frame_pairs, trailer_enable, pause_ticks. pause_ticks returns to 110
//   at the end of every pause.
// Timing:
//   An accepted event passes the input register, then the next-segment logic
//   feeding the result register, which raises out_valid. One event per cycle
//   is sustained while the receiver does not stall; the frame state updates
//   once per event, which sets this rate.
//   When the receiver stalls, the result register holds its beat and the
//   input register fills; in_stall rises once both are occupied.
//   Reset clears the frame state, the stored command and the valid flags of
//   both registers and loads the default settings.
// Depends on rcmm_pkg, rcmm_in_stage, rcmm_seq, rcmm_out_stage.
module rcmm_ir_frame_encoder_core
	import rcmm_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
)(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            mode,
	input  logic [CMD_W-1:0]      command,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  carrier_on,
	output logic [DUR_W-1:0]      duration,
	output logic                  duration_valid,
	output logic                  frame_active,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    adv;
	res_t    res;
	res_t    res_q;
	cfg_wr_t cfg;

	assign in_item.mode    = mode_t'(mode);
	assign in_item.command = command;

	assign cfg.we   = cfg_we;
	assign cfg.idx  = cfg_idx_t'(cfg_idx);
	assign cfg.data = cfg_wdata;

	rcmm_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rcmm_seq #(
		.WORD_BITS (WORD_BITS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.item_s1 (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	rcmm_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res       (res),
		.out_stall (out_stall),
		.adv       (adv),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign carrier_on     = res_q.carrier_on;
	assign duration       = res_q.duration;
	assign duration_valid = res_q.duration_valid;
	assign frame_active   = res_q.frame_active;

endmodule

// ----- hdl/rcmm_chk.sv -----
// Port-level checks of the RCMM encoder, bound to the top level.
// Depends on rcmm_pkg and rcmm_ir_frame_encoder_core.
module rcmm_chk
	import rcmm_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic                  carrier_on,
	input logic [DUR_W-1:0]      duration,
	input logic                  duration_valid,
	input logic                  frame_active
);

	// a stalled result beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(duration) && $stable(carrier_on)
			&& $stable(duration_valid) && $stable(frame_active))
		else $error("result beat changed under stall");

	a_dur_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !duration_valid |-> duration == '0)
		else $error("duration without duration_valid");

	// idle always leaves the carrier off
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_active |-> !carrier_on)
		else $error("carrier on while idle");

	a_mark_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && duration_valid && carrier_on
			|-> duration == HEAD_MARK_LEN || duration == SYM_MARK_LEN)
		else $error("bad mark length");

endmodule

bind rcmm_ir_frame_encoder_core rcmm_chk u_chk (.*);

// ----- sim/tb.sv -----
// Self-checking testbench for the RCMM frame encoder core: directed events,
// a long wrapped frame under receiver hold-off, and random frames under varied idling and stalls.
// Depends on rcmm_pkg and rcmm_ir_frame_encoder_core.
`timescale 1ns / 1ps

module tb;
	import rcmm_pkg::*;

	localparam int WORD_BITS   = WORD_BITS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [CMD_W-1:0] WORD_MASK = {CMD_W{1'b1}} >> (CMD_W - WORD_BITS);

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            mode = MODE_TICK;
	logic [CMD_W-1:0]      command = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  carrier_on;
	logic [DUR_W-1:0]      duration;
	logic                  duration_valid;
	logic                  frame_active;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = CFG_FRAME_PAIRS;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// shadow encoder state and settings
	phase_t               enc_phase = PH_IDLE;
	logic [CMD_W-1:0]     enc_shift = '0;
	logic [PAIRS_W-1:0]   enc_pairs_done = '0;
	logic [PAUSE_W-1:0]   enc_pause_done = '0;
	logic [CMD_W-1:0]     enc_stored = '0;
	logic                 enc_carrier = 1'b0;
	logic [PAIRS_W-1:0]   set_pairs = FRAME_PAIRS_RST;
	logic                 set_trailer = 1'b1;
	logic [PAUSE_W-1:0]   set_pause = PAUSE_TICKS_RST;

	res_t predicted_beats[$];
	int   mismatches = 0;
	int   items_sent = 0;
	int   cycle_count = 0;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   hold_request = 0;
	int   hold_left = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	rcmm_ir_frame_encoder_core #(.WORD_BITS(WORD_BITS)) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.command        (command),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.carrier_on     (carrier_on),
		.duration       (duration),
		.duration_valid (duration_valid),
		.frame_active   (frame_active),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata)
	);

	function automatic logic [DUR_W-1:0] symbol_space(input logic [1:0] sym);
		logic [DUR_W-1:0] len;
		case (sym)
			2'd0:    len = 5'd10;
			2'd1:    len = 5'd16;
			2'd2:    len = 5'd22;
			default: len = 5'd28;
		endcase
		return len;
	endfunction

	// Advances the shadow encoder by one event and returns the segment it issues.
	function automatic res_t encode_event(input mode_t m, input logic [CMD_W-1:0] cmd);
		res_t r;
		r.duration = '0;
		r.duration_valid = 1'b0;
		case (m)
			MODE_SEND, MODE_REPEAT: begin
				if (m == MODE_SEND)
					enc_stored = cmd & WORD_MASK;
				if (enc_stored != '0 && enc_phase == PH_IDLE) begin
					enc_shift = enc_stored;
					enc_phase = PH_HEAD_MARK;
				end
			end
			MODE_STOP: enc_stored = '0;
			default: begin
				case (enc_phase)
					PH_HEAD_MARK: begin
						enc_carrier = 1'b1;
						r.duration = HEAD_MARK_LEN;
						enc_phase = PH_HEAD_SPACE;
					end
					PH_HEAD_SPACE: begin
						enc_carrier = 1'b0;
						r.duration = HEAD_SPACE_LEN;
						enc_phase = PH_SYM_MARK;
					end
					PH_SYM_MARK: begin
						enc_carrier = 1'b1;
						r.duration = SYM_MARK_LEN;
						enc_phase = PH_SYM_SPACE;
					end
					PH_SYM_SPACE: begin
						enc_carrier = 1'b0;
						r.duration = symbol_space(enc_shift[WORD_BITS-1 -: 2]);
						enc_shift = (enc_shift << 2) & WORD_MASK;
						enc_pairs_done = enc_pairs_done + 1'b1;
						enc_phase = (enc_pairs_done == set_pairs) ? PH_TRAIL : PH_SYM_MARK;
					end
					PH_TRAIL: begin
						// trailer off: one-period gap, carrier stays as it was
						if (set_trailer) begin
							enc_carrier = 1'b1;
							r.duration = TRAIL_MARK_LEN;
						end else begin
							r.duration = TRAIL_GAP_LEN;
						end
						enc_phase = PH_PAUSE;
					end
					PH_PAUSE: begin
						enc_carrier = 1'b0;
						r.duration = PAUSE_SEG_LEN;
						enc_pause_done = enc_pause_done + 1'b1;
						if (enc_pause_done >= set_pause) begin
							enc_pairs_done = '0;
							enc_pause_done = '0;
							set_pause = PAUSE_TICKS_RST;
							enc_phase = PH_IDLE;
						end
					end
					default: begin
						enc_carrier = 1'b0;
						enc_phase = PH_IDLE;
					end
				endcase
				r.duration_valid = (r.duration != '0);
			end
		endcase
		r.carrier_on = enc_carrier;
		r.frame_active = (enc_phase != PH_IDLE);
		return r;
	endfunction

	// settings writes and accepted event beats feed the shadow encoder
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_idx))
					CFG_FRAME_PAIRS: set_pairs = cfg_wdata[PAIRS_W-1:0];
					CFG_TRAILER_EN:  set_trailer = cfg_wdata[0];
					CFG_PAUSE_TICKS: set_pause = cfg_wdata[PAUSE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predicted_beats.push_back(encode_event(mode_t'(mode), command));
		end
	end

	always @(posedge clk) begin : check_results
		res_t got;
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {carrier_on, duration, duration_valid, frame_active};
			if (predicted_beats.size() == 0) begin
				$display("%0t: result beat with nothing pending: on=%0b dur=%0d dv=%0b act=%0b",
					$time, got.carrier_on, got.duration, got.duration_valid,
					got.frame_active);
				mismatches++;
			end else begin
				want = predicted_beats.pop_front();
				if (got.carrier_on !== want.carrier_on || got.duration !== want.duration ||
					got.duration_valid !== want.duration_valid ||
					got.frame_active !== want.frame_active) begin
					$display("%0t: expected on=%0b dur=%0d dv=%0b act=%0b, got on=%0b dur=%0d dv=%0b act=%0b",
						$time, want.carrier_on, want.duration, want.duration_valid,
						want.frame_active, got.carrier_on, got.duration,
						got.duration_valid, got.frame_active);
					mismatches++;
				end
			end
		end
	end

	// receiver: random stalls, or a counted hold-off when one is requested
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offers one event beat and returns at the edge it is taken, then, by idle_pct, may drop in_valid and idle.
	task automatic send_event(input mode_t m, input logic [CMD_W-1:0] cmd);
		int gap;
		in_valid <= 1'b1;
		mode <= m;
		command <= cmd;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (predicted_beats.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_directed_events();
		idle_pct = 0;
		stall_pct = 0;
		// one symbol, trailer off, zero pause
		write_reg(CFG_FRAME_PAIRS, 8'hE1);
		write_reg(CFG_TRAILER_EN, 8'hFE);
		write_reg(CFG_PAUSE_TICKS, 8'h00);
		send_event(MODE_TICK, 32'h0);
		send_event(MODE_REPEAT, 32'hFFFF_FFFF);
		send_event(MODE_STOP, 32'h0);
		send_event(MODE_SEND, 32'h0);
		send_event(MODE_SEND, 32'hC000_0000);
		send_event(MODE_TICK, 32'h0);
		send_event(MODE_TICK, 32'h0);
		send_event(MODE_SEND, 32'hFFFF_FFFF);
		send_event(MODE_TICK, 32'h0);
		send_event(MODE_TICK, 32'h0);
		send_event(MODE_TICK, 32'h0);
		send_event(MODE_STOP, 32'h0);
		send_event(MODE_TICK, 32'h0);
		send_event(MODE_REPEAT, 32'h0);
		send_event(MODE_TICK, 32'hFFFF_FFFF);
		drain();
		write_reg(CFG_UNUSED, 8'h5A);
		write_reg(CFG_FRAME_PAIRS, 8'h02);
		write_reg(CFG_TRAILER_EN, 8'h01);
		write_reg(CFG_PAUSE_TICKS, 8'h01);
		send_event(MODE_SEND, 32'h4000_0000);
		repeat (8) send_event(MODE_TICK, 32'h0);
		drain();
	endtask

	// 32 symbols through counter wrap, longest pause, receiver held off at the start
	task automatic test_long_frame_holdoff();
		idle_pct = 0;
		stall_pct = 0;
		drain();
		write_reg(CFG_FRAME_PAIRS, 8'hE0);
		write_reg(CFG_TRAILER_EN, 8'hFF);
		write_reg(CFG_PAUSE_TICKS, 8'hFF);
		hold_request = 120;
		send_event(MODE_SEND, $urandom | 32'h1);
		do begin
			repeat (40) send_event(MODE_TICK, $urandom);
			drain();
		end while (enc_phase != PH_IDLE);
	endtask

	task automatic run_random_frames(input int n_items);
		int    stop_at;
		int    r;
		int    batch;
		mode_t m;
		logic [CMD_W-1:0] cmd;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			drain();
			if (enc_phase == PH_IDLE) begin
				if ($urandom_range(99) < 80) begin
					r = $urandom_range(99);
					if (r < 65)
						write_reg(CFG_FRAME_PAIRS, {3'($urandom), 5'($urandom_range(1, 4))});
					else if (r < 85)
						write_reg(CFG_FRAME_PAIRS, {3'($urandom), 5'($urandom_range(5, 15))});
					else if (r < 92)
						write_reg(CFG_FRAME_PAIRS, 8'd16);
					else if (r < 96)
						write_reg(CFG_FRAME_PAIRS, {3'($urandom), 5'($urandom_range(17, 31))});
					else
						write_reg(CFG_FRAME_PAIRS, {3'($urandom), 5'd0});
				end
				if ($urandom_range(1) != 0)
					write_reg(CFG_TRAILER_EN, 8'($urandom));
				// the pause setting reverts after every frame
				if ($urandom_range(9) != 0) begin
					if ($urandom_range(99) < 80)
						write_reg(CFG_PAUSE_TICKS, 8'($urandom_range(0, 3)));
					else
						write_reg(CFG_PAUSE_TICKS, 8'($urandom_range(4, 12)));
				end
				cmd = ($urandom_range(99) < 8) ? '0 : $urandom;
				send_event(($urandom_range(4) == 0) ? MODE_REPEAT : MODE_SEND, cmd);
			end
			batch = $urandom_range(4, 24);
			repeat (batch) begin
				r = $urandom_range(99);
				if (r < 88)
					m = MODE_TICK;
				else if (r < 92)
					m = MODE_SEND;
				else if (r < 96)
					m = MODE_REPEAT;
				else
					m = MODE_STOP;
				send_event(m, $urandom);
			end
		end
	endtask

	task automatic test_no_idling();
		idle_pct = 0;
		stall_pct = 0;
		run_random_frames(250);
	endtask

	task automatic test_sender_idle();
		idle_pct = 74;
		stall_pct = 0;
		run_random_frames(250);
	endtask

	task automatic test_receiver_stall();
		idle_pct = 0;
		stall_pct = 74;
		run_random_frames(250);
	endtask

	task automatic test_both_idle();
		idle_pct = 20;
		stall_pct = 20;
		run_random_frames(250);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_events();
		test_long_frame_holdoff();
		test_no_idling();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && predicted_beats.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/rcmm_pkg.sv
hdl/rcmm_in_stage.sv
hdl/rcmm_seq.sv
hdl/rcmm_out_stage.sv
hdl/rcmm_ir_frame_encoder_core.sv
hdl/rcmm_chk.sv
sim/tb.sv
